// ===== rtl/gsp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the gesture sensor message parser.
package gsp_pkg;

   localparam int unsigned MaxMsgBytesDefault = 256;

   localparam logic [7:0] MsgIdStatus = 8'h15;
   localparam logic [7:0] MsgIdFwInfo = 8'h83;
   localparam logic [7:0] MsgIdSensor = 8'h91;

   localparam logic [7:0] IdxMsgId    = 8'd3;
   localparam logic [7:0] IdxMaskLo   = 8'd4;
   localparam logic [7:0] IdxMaskHi   = 8'd5;
   localparam logic [7:0] IdxSysInfo  = 8'd7;
   localparam logic [4:0] FieldBase   = 5'd8;
   localparam logic [4:0] WheelLowMask = 5'h1F;

   typedef enum logic [1:0] {
      KIND_STATUS  = 2'd0,
      KIND_FW_INFO = 2'd1,
      KIND_SENSOR  = 2'd2,
      KIND_UNKNOWN = 2'd3
   } msg_kind_type;

   typedef struct packed {
      msg_kind_type msg_kind;
      logic         gesture_valid;
      logic [31:0]  gesture_word;
      logic         touch_valid;
      logic [31:0]  touch_word;
      logic         wheel_valid;
      logic [4:0]   wheel_position;
      logic [2:0]   wheel_count;
      logic         xyz_valid;
      logic [15:0]  pos_x;
      logic [15:0]  pos_y;
      logic [15:0]  pos_z;
   } result_type;

endpackage

// ===== rtl/gsp_field_capture.sv =====
`timescale 1ns / 1ps
// Per-beat message state: byte index, header capture, field offset match and assembly.
module gsp_field_capture #(
   parameter int unsigned MAX_MSG_BYTES = gsp_pkg::MaxMsgBytesDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           rx_byte,
   input  logic                 end_of_msg,
   output logic                 push,
   output gsp_pkg::result_type  result
);

   logic [7:0]  byte_index_ff,  byte_index_in;
   logic [7:0]  message_id_ff,  message_id_in;
   logic [15:0] field_mask_ff,  field_mask_in;
   logic [7:0]  system_info_ff, system_info_in;
   logic [31:0] gesture_ff,     gesture_in;
   logic [31:0] touch_ff,       touch_in;
   logic [7:0]  wheel_ff,       wheel_in;
   logic [47:0] xyz_ff,         xyz_in;
   logic [3:0]  recv_ff,        recv_in;

   logic [7:0]  msg_id_upd;
   logic [15:0] mask_upd;
   logic [7:0]  sys_upd;
   logic [31:0] gesture_upd;
   logic [31:0] touch_upd;
   logic [7:0]  wheel_upd;
   logic [47:0] xyz_upd;
   logic [3:0]  recv_upd;

   logic        in_range;
   logic [4:0]  gpos, tpos, wpos, xpos;
   logic [7:0]  gdiff, tdiff, xdiff;
   logic        g_hit, t_hit, x_hit, x_en;
   logic        sensor, gv, tv, wv, xv;

   always_comb begin
      in_range = {1'b0, byte_index_ff} < 9'(MAX_MSG_BYTES);

      gpos = gsp_pkg::FieldBase + (field_mask_ff[0] ? 5'd2 : 5'd0);
      tpos = gpos + (field_mask_ff[1] ? 5'd4 : 5'd0);
      wpos = tpos + (field_mask_ff[2] ? 5'd4 : 5'd0);
      xpos = wpos + (field_mask_ff[3] ? 5'd2 : 5'd0);

      gdiff = byte_index_ff - {3'b000, gpos};
      tdiff = byte_index_ff - {3'b000, tpos};
      xdiff = byte_index_ff - {3'b000, xpos};

      x_en  = field_mask_ff[4] && system_info_ff[0];
      g_hit = in_range && field_mask_ff[1] && (byte_index_ff >= {3'b000, gpos})
              && (gdiff < 8'd4);
      t_hit = in_range && field_mask_ff[2] && (byte_index_ff >= {3'b000, tpos})
              && (tdiff < 8'd4);
      x_hit = in_range && x_en && (byte_index_ff >= {3'b000, xpos}) && (xdiff < 8'd6);

      msg_id_upd  = message_id_ff;
      mask_upd    = field_mask_ff;
      sys_upd     = system_info_ff;
      gesture_upd = gesture_ff;
      touch_upd   = touch_ff;
      wheel_upd   = wheel_ff;
      xyz_upd     = xyz_ff;
      recv_upd    = recv_ff;

      if (in_range) begin
         if (byte_index_ff == gsp_pkg::IdxMsgId) msg_id_upd = rx_byte;
         if (byte_index_ff == gsp_pkg::IdxMaskLo) mask_upd[7:0] = rx_byte;
         if (byte_index_ff == gsp_pkg::IdxMaskHi) mask_upd[15:8] = rx_byte;
         if (byte_index_ff == gsp_pkg::IdxSysInfo) sys_upd = rx_byte;
      end
      if (g_hit) begin
         gesture_upd = gesture_ff | (32'(rx_byte) << {gdiff[1:0], 3'b000});
         if (gdiff[1:0] == 2'd3) recv_upd[0] = 1'b1;
      end
      if (t_hit) begin
         touch_upd = touch_ff | (32'(rx_byte) << {tdiff[1:0], 3'b000});
         if (tdiff[1:0] == 2'd3) recv_upd[1] = 1'b1;
      end
      if (in_range && field_mask_ff[3]) begin
         if (byte_index_ff == {3'b000, wpos}) wheel_upd = rx_byte;
         if (byte_index_ff == {3'b000, wpos} + 8'd1) recv_upd[2] = 1'b1;
      end
      if (x_hit) begin
         xyz_upd = xyz_ff | (48'(rx_byte) << {xdiff[2:0], 3'b000});
         if (xdiff[2:0] == 3'd5) recv_upd[3] = 1'b1;
      end

      case (msg_id_upd)
         gsp_pkg::MsgIdStatus: result.msg_kind = gsp_pkg::KIND_STATUS;
         gsp_pkg::MsgIdFwInfo: result.msg_kind = gsp_pkg::KIND_FW_INFO;
         gsp_pkg::MsgIdSensor: result.msg_kind = gsp_pkg::KIND_SENSOR;
         default:              result.msg_kind = gsp_pkg::KIND_UNKNOWN;
      endcase
      sensor = (result.msg_kind == gsp_pkg::KIND_SENSOR);
      gv = sensor && mask_upd[1] && recv_upd[0];
      tv = sensor && mask_upd[2] && recv_upd[1];
      wv = sensor && mask_upd[3] && sys_upd[1] && recv_upd[2];
      xv = sensor && mask_upd[4] && sys_upd[0] && recv_upd[3];

      result.gesture_valid  = gv;
      result.gesture_word   = gv ? gesture_upd : 32'd0;
      result.touch_valid    = tv;
      result.touch_word     = tv ? touch_upd : 32'd0;
      result.wheel_valid    = wv;
      result.wheel_position = wv ? (wheel_upd[4:0] & gsp_pkg::WheelLowMask) : 5'd0;
      result.wheel_count    = wv ? wheel_upd[7:5] : 3'd0;
      result.xyz_valid      = xv;
      result.pos_x          = xv ? xyz_upd[15:0]  : 16'd0;
      result.pos_y          = xv ? xyz_upd[31:16] : 16'd0;
      result.pos_z          = xv ? xyz_upd[47:32] : 16'd0;

      push = accept && end_of_msg;

      byte_index_in  = (byte_index_ff == 8'hFF) ? byte_index_ff : byte_index_ff + 8'd1;
      message_id_in  = msg_id_upd;
      field_mask_in  = mask_upd;
      system_info_in = sys_upd;
      gesture_in     = gesture_upd;
      touch_in       = touch_upd;
      wheel_in       = wheel_upd;
      xyz_in         = xyz_upd;
      recv_in        = recv_upd;
      if (end_of_msg) begin
         byte_index_in  = 8'd0;
         message_id_in  = 8'd0;
         field_mask_in  = 16'd0;
         system_info_in = 8'd0;
         gesture_in     = 32'd0;
         touch_in       = 32'd0;
         wheel_in       = 8'd0;
         xyz_in         = 48'd0;
         recv_in        = 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff  <= 8'd0;
         message_id_ff  <= 8'd0;
         field_mask_ff  <= 16'd0;
         system_info_ff <= 8'd0;
         gesture_ff     <= 32'd0;
         touch_ff       <= 32'd0;
         wheel_ff       <= 8'd0;
         xyz_ff         <= 48'd0;
         recv_ff        <= 4'd0;
      end else if (accept) begin
         byte_index_ff  <= byte_index_in;
         message_id_ff  <= message_id_in;
         field_mask_ff  <= field_mask_in;
         system_info_ff <= system_info_in;
         gesture_ff     <= gesture_in;
         touch_ff       <= touch_in;
         wheel_ff       <= wheel_in;
         xyz_ff         <= xyz_in;
         recv_ff        <= recv_in;
      end
   end

   a_restart_after_last: assert property (@(posedge clock) disable iff (reset)
      (accept && end_of_msg) |=> (byte_index_ff == 8'd0 && recv_ff == 4'd0))
      else $error("message state not cleared after last beat");

   a_index_advance: assert property (@(posedge clock) disable iff (reset)
      (accept && !end_of_msg && byte_index_ff != 8'hFF)
      |=> (byte_index_ff == $past(byte_index_ff) + 8'd1))
      else $error("byte index did not advance");

   a_recv_needs_mask: assert property (@(posedge clock) disable iff (reset)
      (!recv_ff[0] || field_mask_ff[1]) && (!recv_ff[1] || field_mask_ff[2])
      && (!recv_ff[2] || field_mask_ff[3]) && (!recv_ff[3] || field_mask_ff[4]))
      else $error("field marked received without its mask bit");

endmodule

// ===== rtl/gsp_result_buffer.sv =====
`timescale 1ns / 1ps
// Two-entry result register with skid stage between the parser and the result channel.
module gsp_result_buffer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  gsp_pkg::result_type  push_data,
   input  logic                 out_stall,
   output logic                 out_valid,
   output gsp_pkg::result_type  out_data,
   output logic                 full
);

   logic                main_valid_ff, main_valid_in;
   logic                skid_valid_ff, skid_valid_in;
   gsp_pkg::result_type main_ff, main_in;
   gsp_pkg::result_type skid_ff, skid_in;
   logic                pop;

   always_comb begin
      pop           = main_valid_ff && !out_stall;
      main_valid_in = main_valid_ff;
      main_in       = main_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff || pop) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = push;
            main_in       = push_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_in       = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;
   assign full      = skid_valid_ff;

   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry held while output register empty");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !push)
      else $error("result pushed into full buffer");

   a_skid_refills_main: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && pop) |=> (main_valid_ff && !skid_valid_ff))
      else $error("skid entry lost on drain");

endmodule

// ===== rtl/gesture_sensor_message_parser.sv =====
`timescale 1ns / 1ps
// Top level of the gesture sensor message parser.
// Takes one message byte per beat on the req_ channel at a sustained rate of one beat
// per clock while req_stall is low; header bytes and field bytes are matched against
// offsets derived from the field mask and captured in the same cycle. The beat carrying
// req_end_of_msg yields one result, registered in a two-entry output buffer that feeds
// the rsp_ channel, and the parser is ready for the next message immediately; req_stall
// is high while both entries are occupied, which happens only after the result channel
// has stalled. Bytes at index MAX_MSG_BYTES and beyond are ignored.
module gesture_sensor_message_parser #(
   parameter int unsigned MAX_MSG_BYTES = gsp_pkg::MaxMsgBytesDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_end_of_msg,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_msg_kind,
   output logic        rsp_gesture_valid,
   output logic [31:0] rsp_gesture_word,
   output logic        rsp_touch_valid,
   output logic [31:0] rsp_touch_word,
   output logic        rsp_wheel_valid,
   output logic [4:0]  rsp_wheel_position,
   output logic [2:0]  rsp_wheel_count,
   output logic        rsp_xyz_valid,
   output logic [15:0] rsp_pos_x,
   output logic [15:0] rsp_pos_y,
   output logic [15:0] rsp_pos_z
);

   logic                accept;
   logic                push;
   logic                full;
   gsp_pkg::result_type result;
   gsp_pkg::result_type out_data;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   gsp_field_capture #(
      .MAX_MSG_BYTES(MAX_MSG_BYTES)
   ) u_capture (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .rx_byte    (req_rx_byte),
      .end_of_msg (req_end_of_msg),
      .push       (push),
      .result     (result)
   );

   gsp_result_buffer u_buffer (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (result),
      .out_stall (rsp_stall),
      .out_valid (rsp_valid),
      .out_data  (out_data),
      .full      (full)
   );

   assign rsp_msg_kind       = out_data.msg_kind;
   assign rsp_gesture_valid  = out_data.gesture_valid;
   assign rsp_gesture_word   = out_data.gesture_word;
   assign rsp_touch_valid    = out_data.touch_valid;
   assign rsp_touch_word     = out_data.touch_word;
   assign rsp_wheel_valid    = out_data.wheel_valid;
   assign rsp_wheel_position = out_data.wheel_position;
   assign rsp_wheel_count    = out_data.wheel_count;
   assign rsp_xyz_valid      = out_data.xyz_valid;
   assign rsp_pos_x          = out_data.pos_x;
   assign rsp_pos_y          = out_data.pos_y;
   assign rsp_pos_z          = out_data.pos_z;

endmodule

// ===== tb/sv/gsp_result_checker.sv =====
`timescale 1ns / 1ps
// Checker for the gesture sensor message parser: tracks frames and compares parse results.
module gsp_result_checker #(
   parameter int unsigned MAX_BYTES = gsp_pkg::MaxMsgBytesDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_end_of_msg,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_msg_kind,
   input  logic        rsp_gesture_valid,
   input  logic [31:0] rsp_gesture_word,
   input  logic        rsp_touch_valid,
   input  logic [31:0] rsp_touch_word,
   input  logic        rsp_wheel_valid,
   input  logic [4:0]  rsp_wheel_position,
   input  logic [2:0]  rsp_wheel_count,
   input  logic        rsp_xyz_valid,
   input  logic [15:0] rsp_pos_x,
   input  logic [15:0] rsp_pos_y,
   input  logic [15:0] rsp_pos_z,
   output logic [31:0] error_count,
   output logic [31:0] pending,
   output logic [31:0] checked
);

   logic [7:0]  idx;
   logic [7:0]  msg_id;
   logic [15:0] fmask;
   logic [7:0]  sinfo;
   logic [31:0] gest_acc;
   logic [31:0] touch_acc;
   logic [7:0]  wheel_b;
   logic [47:0] xyz_acc;
   logic [3:0]  got;

   gsp_pkg::result_type parse_results_due[$];

   task automatic clear_frame();
      idx = '0;
      msg_id = '0;
      fmask = '0;
      sinfo = '0;
      gest_acc = '0;
      touch_acc = '0;
      wheel_b = '0;
      xyz_acc = '0;
      got = '0;
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] seen);
      if (want !== seen) begin
         $error("%s: expected %0h, got %0h", name, want, seen);
         error_count = error_count + 1;
      end
   endtask

   task automatic parse_byte(input logic [7:0] b, input logic last);
      int i;
      int pos;
      gsp_pkg::result_type res;
      i = idx;
      if (i < MAX_BYTES) begin
         if (i == gsp_pkg::IdxMsgId) msg_id = b;
         else if (i == gsp_pkg::IdxMaskLo) fmask[7:0] = b;
         else if (i == gsp_pkg::IdxMaskHi) fmask[15:8] = b;
         else if (i == gsp_pkg::IdxSysInfo) sinfo = b;
         else if (i >= gsp_pkg::FieldBase) begin
            pos = gsp_pkg::FieldBase;
            if (fmask[0]) pos += 2;
            if (fmask[1]) begin
               if (i >= pos && i < pos + 4) begin
                  gest_acc = gest_acc | ({24'd0, b} << (8 * (i - pos)));
                  if (i == pos + 3) got[0] = 1'b1;
               end
               pos += 4;
            end
            if (fmask[2]) begin
               if (i >= pos && i < pos + 4) begin
                  touch_acc = touch_acc | ({24'd0, b} << (8 * (i - pos)));
                  if (i == pos + 3) got[1] = 1'b1;
               end
               pos += 4;
            end
            if (fmask[3]) begin
               if (i == pos) wheel_b = b;
               if (i == pos + 1) got[2] = 1'b1;
               pos += 2;
            end
            if (fmask[4] && sinfo[0]) begin
               if (i >= pos && i < pos + 6) begin
                  xyz_acc = xyz_acc | ({40'd0, b} << (8 * (i - pos)));
                  if (i == pos + 5) got[3] = 1'b1;
               end
            end
         end
      end
      if (idx != 8'hFF) idx = idx + 8'd1;
      if (last) begin
         res = '0;
         case (msg_id)
            gsp_pkg::MsgIdStatus: res.msg_kind = gsp_pkg::KIND_STATUS;
            gsp_pkg::MsgIdFwInfo: res.msg_kind = gsp_pkg::KIND_FW_INFO;
            gsp_pkg::MsgIdSensor: res.msg_kind = gsp_pkg::KIND_SENSOR;
            default:              res.msg_kind = gsp_pkg::KIND_UNKNOWN;
         endcase
         if (res.msg_kind == gsp_pkg::KIND_SENSOR) begin
            if (fmask[1] && got[0]) begin
               res.gesture_valid = 1'b1;
               res.gesture_word = gest_acc;
            end
            if (fmask[2] && got[1]) begin
               res.touch_valid = 1'b1;
               res.touch_word = touch_acc;
            end
            if (fmask[3] && sinfo[1] && got[2]) begin
               res.wheel_valid = 1'b1;
               res.wheel_position = wheel_b[4:0];
               res.wheel_count = wheel_b[7:5];
            end
            if (fmask[4] && sinfo[0] && got[3]) begin
               res.xyz_valid = 1'b1;
               res.pos_x = xyz_acc[15:0];
               res.pos_y = xyz_acc[31:16];
               res.pos_z = xyz_acc[47:32];
            end
         end
         parse_results_due.push_back(res);
         clear_frame();
      end
   endtask

   always @(posedge clock) begin
      gsp_pkg::result_type want;
      if (reset) begin
         clear_frame();
         parse_results_due.delete();
         error_count = '0;
         checked = '0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (parse_results_due.size() == 0) begin
               $error("result beat with no frame outstanding");
               error_count = error_count + 1;
            end else begin
               want = parse_results_due.pop_front();
               check_field("msg_kind", 32'(want.msg_kind), 32'(rsp_msg_kind));
               check_field("gesture_valid", 32'(want.gesture_valid),
                           32'(rsp_gesture_valid));
               check_field("gesture_word", want.gesture_word, rsp_gesture_word);
               check_field("touch_valid", 32'(want.touch_valid), 32'(rsp_touch_valid));
               check_field("touch_word", want.touch_word, rsp_touch_word);
               check_field("wheel_valid", 32'(want.wheel_valid), 32'(rsp_wheel_valid));
               check_field("wheel_position", 32'(want.wheel_position),
                           32'(rsp_wheel_position));
               check_field("wheel_count", 32'(want.wheel_count), 32'(rsp_wheel_count));
               check_field("xyz_valid", 32'(want.xyz_valid), 32'(rsp_xyz_valid));
               check_field("pos_x", 32'(want.pos_x), 32'(rsp_pos_x));
               check_field("pos_y", 32'(want.pos_y), 32'(rsp_pos_y));
               check_field("pos_z", 32'(want.pos_z), 32'(rsp_pos_z));
               checked = checked + 1;
            end
         end
         if (req_valid && !req_stall) parse_byte(req_rx_byte, req_end_of_msg);
      end
      pending = parse_results_due.size();
   end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Top of the parser testbench: clock, reset, frame stimulus and the final verdict.
module testbench;

   localparam int CycleLimit = 200000;
   localparam int RandomBytes = 270;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'd0;
   logic        req_end_of_msg = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_msg_kind;
   logic        rsp_gesture_valid;
   logic [31:0] rsp_gesture_word;
   logic        rsp_touch_valid;
   logic [31:0] rsp_touch_word;
   logic        rsp_wheel_valid;
   logic [4:0]  rsp_wheel_position;
   logic [2:0]  rsp_wheel_count;
   logic        rsp_xyz_valid;
   logic [15:0] rsp_pos_x;
   logic [15:0] rsp_pos_y;
   logic [15:0] rsp_pos_z;

   logic [31:0] error_count;
   logic [31:0] pending;
   logic [31:0] checked;

   logic        calm = 1'b0;
   int          cycle_count = 0;
   int          frame_count = 0;
   int          byte_count = 0;
   logic [7:0]  frame[0:511];
   int          frame_len;

   gesture_sensor_message_parser dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_rx_byte(req_rx_byte),
      .req_end_of_msg(req_end_of_msg),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_msg_kind(rsp_msg_kind),
      .rsp_gesture_valid(rsp_gesture_valid),
      .rsp_gesture_word(rsp_gesture_word),
      .rsp_touch_valid(rsp_touch_valid),
      .rsp_touch_word(rsp_touch_word),
      .rsp_wheel_valid(rsp_wheel_valid),
      .rsp_wheel_position(rsp_wheel_position),
      .rsp_wheel_count(rsp_wheel_count),
      .rsp_xyz_valid(rsp_xyz_valid),
      .rsp_pos_x(rsp_pos_x),
      .rsp_pos_y(rsp_pos_y),
      .rsp_pos_z(rsp_pos_z)
   );

   gsp_result_checker u_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_rx_byte(req_rx_byte),
      .req_end_of_msg(req_end_of_msg),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_msg_kind(rsp_msg_kind),
      .rsp_gesture_valid(rsp_gesture_valid),
      .rsp_gesture_word(rsp_gesture_word),
      .rsp_touch_valid(rsp_touch_valid),
      .rsp_touch_word(rsp_touch_word),
      .rsp_wheel_valid(rsp_wheel_valid),
      .rsp_wheel_position(rsp_wheel_position),
      .rsp_wheel_count(rsp_wheel_count),
      .rsp_xyz_valid(rsp_xyz_valid),
      .rsp_pos_x(rsp_pos_x),
      .rsp_pos_y(rsp_pos_y),
      .rsp_pos_z(rsp_pos_z),
      .error_count(error_count),
      .pending(pending),
      .checked(checked)
   );

   always #1 clock = ~clock;

   always @(negedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < 7);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("status: fail");
         $finish;
      end
   end

   task automatic send_beat(input logic [7:0] b, input logic last);
      @(negedge clock);
      while (!calm && $urandom_range(99) < 7) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      req_end_of_msg <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_frame();
      int n;
      for (n = 0; n < frame_len; n++) send_beat(frame[n], n == frame_len - 1);
      frame_count++;
      byte_count += frame_len;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   // fill: 0 random, 1 all zeros, 2 all ones
   task automatic build_plain(input logic [7:0] id, input int len, input int fill);
      int n;
      frame_len = len;
      for (n = 0; n < len; n++)
         frame[n] = (fill == 1) ? 8'h00 : (fill == 2) ? 8'hFF : 8'($urandom_range(255));
      if (len > gsp_pkg::IdxMsgId) frame[gsp_pkg::IdxMsgId] = id;
   endtask

   task automatic build_sensor(input logic [15:0] mask, input logic [7:0] info,
                               input int trail, input int cut, input int fill);
      int body;
      body = 0;
      if (mask[0]) body += 2;
      if (mask[1]) body += 4;
      if (mask[2]) body += 4;
      if (mask[3]) body += 2;
      if (mask[4] && info[0]) body += 6;
      build_plain(gsp_pkg::MsgIdSensor, gsp_pkg::FieldBase + body + trail, fill);
      frame[gsp_pkg::IdxMaskLo] = mask[7:0];
      frame[gsp_pkg::IdxMaskHi] = mask[15:8];
      frame[gsp_pkg::IdxSysInfo] = info;
      if (cut > 0 && cut < frame_len) frame_len = cut;
   endtask

   initial begin
      int r;
      int target;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      build_plain(8'h00, 1, 0); send_frame();
      build_plain(gsp_pkg::MsgIdSensor, 3, 2); send_frame();
      build_plain(gsp_pkg::MsgIdStatus, 4, 0); send_frame();
      build_plain(gsp_pkg::MsgIdFwInfo, 6, 2); send_frame();
      build_plain(8'hFF, 5, 1); send_frame();
      build_plain(gsp_pkg::MsgIdSensor, 4, 0); send_frame();
      build_sensor(16'h001F, 8'h03, 0, 0, 2); send_frame();
      build_sensor(16'h001F, 8'h03, 0, 0, 1); send_frame();
      build_sensor(16'hFFFF, 8'h00, 2, 0, 0); send_frame();
      build_sensor(16'h001E, 8'h01, 0, 0, 0); send_frame();
      build_sensor(16'h0006, 8'h03, 0, 13, 0); send_frame();
      build_sensor(16'h0000, 8'hFF, 1, 0, 0); send_frame();
      build_plain(gsp_pkg::MsgIdStatus, 20, 0); send_frame();
      build_sensor(16'h001F, 8'h03, 244, 0, 0); send_frame();
      wait_drained();

      target = byte_count + RandomBytes;
      while (byte_count < target) begin
         calm <= (frame_count >= 16 && frame_count < 24);
         r = $urandom_range(99);
         if (r < 75)
            build_sensor(16'($urandom_range(65535)), 8'($urandom_range(255)),
                         $urandom_range(3),
                         ($urandom_range(99) < 15) ? $urandom_range(1, 30) : 0, 0);
         else if (r < 85)
            build_plain((r < 80) ? gsp_pkg::MsgIdStatus : gsp_pkg::MsgIdFwInfo,
                        $urandom_range(1, 12), 0);
         else if (r < 98)
            build_plain(8'($urandom_range(255)), $urandom_range(1, 30), 0);
         else
            build_sensor(16'($urandom_range(65535)), 8'($urandom_range(255)),
                         $urandom_range(230, 260), 0, 0);
         send_frame();
         if (frame_count % 25 == 0) wait_drained();
      end
      calm <= 1'b0;

      wait_drained();
      repeat (8) @(negedge clock);
      $display("sent %0d frames, %0d bytes: all kinds, short, truncated and overlong frames",
               frame_count, byte_count);
      $display("compared %0d parse results, %0d mismatches", checked, error_count);
      if (error_count == 0 && pending == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/gsp_pkg.sv
rtl/gsp_field_capture.sv
rtl/gsp_result_buffer.sv
rtl/gesture_sensor_message_parser.sv
tb/sv/gsp_result_checker.sv
tb/sv/testbench.sv
